FILE: sv/sh2w_pkg.sv
// shared types, constants and round functions for the two-word siphash block
// no dependencies; used by sh2w_cell and siphash_two_word_hash
package sh2w_pkg;

  // seed constants of the hash
  localparam logic [63:0] C0 = 64'h736f_6d65_7073_6575;
  localparam logic [63:0] C1 = 64'h646f_7261_6e64_6f6d;
  localparam logic [63:0] C2 = 64'h6c79_6765_6e65_7261;
  localparam logic [63:0] C3 = 64'h7465_6462_7974_6573;

  // length word for a 16-byte message, and the finalization mark
  localparam logic [63:0] LenWord   = 64'h1000_0000_0000_0000;
  localparam logic [63:0] FinalMark = 64'h0000_0000_0000_00ff;

  // each cell runs one half of a round
  localparam int unsigned HalvesPerRound = 2;
  localparam int unsigned AbsorbRounds   = 2;
  localparam int unsigned FinalRounds    = 4;
  localparam int unsigned AbsorbCells    = AbsorbRounds * HalvesPerRound;
  localparam int unsigned EndFirst       = AbsorbCells - 1;
  localparam int unsigned EndSecond      = 2 * AbsorbCells - 1;
  localparam int unsigned EndLen         = 3 * AbsorbCells - 1;
  localparam int unsigned NumCells       = 3 * AbsorbCells + FinalRounds * HalvesPerRound;

  // configuration register indexes
  localparam int unsigned CfgIndexWidth = 8;
  localparam logic [CfgIndexWidth-1:0] RegKeyLow  = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegKeyHigh = 8'd1;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  // what one cell hands to the next: lanes plus the words still to absorb
  typedef struct packed {
    lanes_t      lanes;
    logic [63:0] w0;
    logic [63:0] w1;
  } cell_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
    rotl64 = (x << n) | (x >> (64 - n));
  endfunction

  // first half of a round: adds into lanes zero and two
  function automatic lanes_t half_a(input lanes_t s);
    lanes_t r;
    r.v0 = s.v0 + s.v1;
    r.v1 = rotl64(s.v1, 13) ^ r.v0;
    r.v0 = rotl64(r.v0, 32);
    r.v2 = s.v2 + s.v3;
    r.v3 = rotl64(s.v3, 16) ^ r.v2;
    half_a = r;
  endfunction

  // second half of a round: cross adds, lane two rotated at the end
  function automatic lanes_t half_b(input lanes_t s);
    lanes_t r;
    r.v0 = s.v0 + s.v3;
    r.v3 = rotl64(s.v3, 21) ^ r.v0;
    r.v2 = s.v2 + s.v1;
    r.v1 = rotl64(s.v1, 17) ^ r.v2;
    r.v2 = rotl64(r.v2, 32);
    half_b = r;
  endfunction

  // initial lanes from the key, with the first word already mixed into lane three
  function automatic lanes_t seed(input logic [63:0] k0, input logic [63:0] k1,
                                  input logic [63:0] m);
    lanes_t r;
    r.v0 = C0 ^ k0;
    r.v1 = C1 ^ k1;
    r.v2 = C2 ^ k0;
    r.v3 = C3 ^ k1 ^ m;
    seed = r;
  endfunction

endpackage

FILE: sv/sh2w_cell.sv
// one pipeline cell: half a round plus the message mixing at absorb boundaries
// depends on sh2w_pkg
module sh2w_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  sh2w_pkg::cell_t in_data,
  input  logic            in_valid,
  output logic            in_ready,
  output sh2w_pkg::cell_t out_data,
  output logic            out_valid,
  input  logic            out_ready
);

  localparam bit IsSecondHalf = (STAGE % sh2w_pkg::HalvesPerRound) == 1;

  sh2w_pkg::cell_t data_next;
  sh2w_pkg::cell_t data;
  logic            valid;

  // half round, then xor in the words that close or open an absorb, and the finalization mark
  always_comb begin
    data_next = in_data;
    data_next.lanes = IsSecondHalf ? sh2w_pkg::half_b(in_data.lanes)
                                   : sh2w_pkg::half_a(in_data.lanes);
    if (STAGE == sh2w_pkg::EndFirst) begin
      data_next.lanes.v0 = data_next.lanes.v0 ^ in_data.w0;
      data_next.lanes.v3 = data_next.lanes.v3 ^ in_data.w1;
    end else if (STAGE == sh2w_pkg::EndSecond) begin
      data_next.lanes.v0 = data_next.lanes.v0 ^ in_data.w1;
      data_next.lanes.v3 = data_next.lanes.v3 ^ sh2w_pkg::LenWord;
    end else if (STAGE == sh2w_pkg::EndLen) begin
      data_next.lanes.v0 = data_next.lanes.v0 ^ sh2w_pkg::LenWord;
      data_next.lanes.v2 = data_next.lanes.v2 ^ sh2w_pkg::FinalMark;
    end
  end

  // a cell takes an item when empty or when its own item moves on
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_data  = data;
  assign out_valid = valid;

endmodule

FILE: sv/siphash_two_word_hash.sv
// keyed siphash-2-4 of a 16-byte message as a chain of half-round cells
// depends on sh2w_pkg and sh2w_cell
//
// usage:
//   the key is written on the cfg channel (index 0 key_low, index 1 key_high,
//   other indexes ignored); cfg_ready is always high. write the key only while
//   no item is in flight.
//   s_axis carries one message per item: first_word in tdata[63:0],
//   second_word in tdata[127:64]. m_axis returns the 64-bit hash per item.
//   throughput: one item per cycle while s_axis_tready is high. the chain has 20
//   cells, each one half of a siphash round, followed by an output register that
//   folds the lanes. each cell hands its item on when the next one is empty or
//   moving, so the chain keeps taking items while a result waits; when m_axis
//   stalls long enough, the chain fills and s_axis_tready drops.
//   reset empties every cell and the output register and clears the key.
module siphash_two_word_hash (
  input  logic                                clk,
  input  logic                                rst,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sh2w_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [63:0]                         cfg_data,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [127:0]                        s_axis_tdata,  // first_word, second_word
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [63:0]                         m_axis_tdata   // hash_value
);

  localparam int unsigned NumCells = sh2w_pkg::NumCells;

  logic [63:0]     key_low;
  logic [63:0]     key_high;
  sh2w_pkg::cell_t link_data  [NumCells+1];
  logic            link_valid [NumCells+1];
  logic            link_ready [NumCells+1];
  logic [63:0]     hash;
  logic            hash_valid;

  // key registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sh2w_pkg::RegKeyLow:  key_low  <= cfg_data;
        sh2w_pkg::RegKeyHigh: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // seed the first cell from the key and the incoming item
  always_comb begin
    link_data[0].lanes = sh2w_pkg::seed(key_low, key_high, s_axis_tdata[63:0]);
    link_data[0].w0    = s_axis_tdata[63:0];
    link_data[0].w1    = s_axis_tdata[127:64];
  end
  assign link_valid[0] = s_axis_tvalid;
  assign s_axis_tready = link_ready[0];

  // chain of half-round cells
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    sh2w_cell #(
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_data   (link_data[i]),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .out_data  (link_data[i+1]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1])
    );
  end

  // output register folds the four lanes
  assign link_ready[NumCells] = !hash_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (link_ready[NumCells]) begin
      hash_valid <= link_valid[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (link_ready[NumCells] && link_valid[NumCells]) begin
      hash <= link_data[NumCells].lanes.v0 ^ link_data[NumCells].lanes.v1 ^
              link_data[NumCells].lanes.v2 ^ link_data[NumCells].lanes.v3;
    end
  end

  assign m_axis_tvalid = hash_valid;
  assign m_axis_tdata  = hash;

`ifndef SYNTHESIS
  // an empty first cell always takes an item
  a_first_cell_ready: assert property (@(posedge clk) disable iff (rst)
    !link_valid[1] |-> s_axis_tready)
    else $error("first cell empty but input not ready");

  // an item in the last cell moves into a free output register
  a_last_cell_drains: assert property (@(posedge clk) disable iff (rst)
    (link_valid[NumCells] && !hash_valid) |=> hash_valid)
    else $error("last cell item did not reach the output register");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !link_valid[NumCells]))
    else $error("result offered right after reset");
`endif

endmodule
